@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SCW_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

// The consequent must hold in the same cycle as the antecedent.
`define SCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ rtl/core/scw_pkg.sv @@
// Shared types, request codes and constants of the strided chain copy walker.
package scw_pkg;

    // Default sizing of the record tables and the address path.
    localparam int MAX_RECORDS_DEF = 16;
    localparam int ADDR_BITS_DEF   = 48;

    // Fixed field widths.
    localparam int START_W  = 48;
    localparam int ES_W     = 9;
    localparam int STRIDE_W = 16;
    localparam int LEN_W    = 16;
    localparam int BCNT_W   = 24;
    localparam int DELTA_W  = BCNT_W + STRIDE_W;

    // Largest element size that a record keeps.
    localparam logic [ES_W-1:0] ES_MAX = 9'd256;

    // Request codes.
    localparam logic [1:0] REQ_LOAD_SRC = 2'd0;
    localparam logic [1:0] REQ_LOAD_DST = 2'd1;
    localparam logic [1:0] REQ_STEP     = 2'd2;
    localparam logic [1:0] REQ_CLEAR    = 2'd3;

    // One strided record as held in a table.
    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [ES_W-1:0]     esize;
        logic [STRIDE_W-1:0] stride;
        logic [LEN_W-1:0]    length;
    } rec_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_src;
        logic load_dst;
        logic clear;
        logic emit_idle;
        logic rd_cur;
        logic calc;
        logic mul;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic src_done;
        logic dst_done;
    } dp_sts_t;

endpackage

@@ rtl/core/scw_ctrl.sv @@
// Controller state machine that sequences loads, clears and copy steps.
`include "assert_macros.svh"

module scw_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    input  scw_pkg::dp_sts_t  sts,
    output scw_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import scw_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CALC   = 2'd1;
    localparam logic [1:0] S_MUL    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_LOAD_SRC: cmd.load_src = 1'b1;
                        REQ_LOAD_DST: cmd.load_dst = 1'b1;
                        REQ_CLEAR:    cmd.clear    = 1'b1;
                        REQ_STEP:
                        begin
                            if (sts.src_done || sts.dst_done)
                            begin
                                cmd.emit_idle = 1'b1;
                            end
                            else
                            begin
                                cmd.rd_cur = 1'b1;
                                state_next = S_CALC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    // A step that starts a record read always runs into the calculation cycle.
    `SCW_ASSERT_NEXT(a_rd_then_calc, clk, rst_n, cmd.rd_cur, cmd.calc)

endmodule

@@ rtl/core/scw_dp.sv @@
// Datapath: record tables, chain pointers, step arithmetic and result registers.
`include "assert_macros.svh"

module scw_dp #(
    parameter int MAX_RECORDS = scw_pkg::MAX_RECORDS_DEF,
    parameter int ADDR_BITS   = scw_pkg::ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  scw_pkg::dp_cmd_t                cmd,
    output scw_pkg::dp_sts_t                sts,
    input  logic [scw_pkg::START_W-1:0]     rec_start,
    input  logic [scw_pkg::ES_W-1:0]        rec_elem_size,
    input  logic [scw_pkg::STRIDE_W-1:0]    rec_stride,
    input  logic [scw_pkg::LEN_W-1:0]       rec_length,
    output logic [scw_pkg::START_W-1:0]     src_addr,
    output logic [scw_pkg::START_W-1:0]     dst_addr,
    output logic [scw_pkg::BCNT_W-1:0]      byte_count,
    output logic                            last_cmd,
    output logic                            chain_error,
    output logic                            done
);
    import scw_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    // Record tables and their registered read ports.
    rec_t src_mem [0:MAX_RECORDS-1];
    rec_t dst_mem [0:MAX_RECORDS-1];
    rec_t src_rd_reg;
    rec_t dst_rd_reg;

    // Chain walking state.
    logic [CNT_W-1:0]     src_count_reg, src_count_next;
    logic [CNT_W-1:0]     dst_count_reg, dst_count_next;
    logic [CNT_W-1:0]     src_idx_reg, src_idx_next;
    logic [CNT_W-1:0]     dst_idx_reg, dst_idx_next;
    logic [LEN_W-1:0]     src_pos_reg, src_pos_next;
    logic [LEN_W-1:0]     dst_pos_reg, dst_pos_next;
    logic [ADDR_BITS-1:0] src_ptr_reg, src_ptr_next;
    logic [ADDR_BITS-1:0] dst_ptr_reg, dst_ptr_next;

    // Step pipeline registers.
    logic [LEN_W-1:0]    elems_reg;
    logic [BCNT_W-1:0]   bcnt_reg;
    logic [STRIDE_W-1:0] src_stride_reg;
    logic [STRIDE_W-1:0] dst_stride_reg;
    logic [LEN_W-1:0]    src_len_reg;
    logic [LEN_W-1:0]    dst_len_reg;
    logic                mismatch_reg;
    logic [DELTA_W-1:0]  src_delta_reg;
    logic [DELTA_W-1:0]  dst_delta_reg;

    // Result registers.
    logic [START_W-1:0] src_addr_reg;
    logic [START_W-1:0] dst_addr_reg;
    logic [BCNT_W-1:0]  byte_count_reg;
    logic               last_reg;
    logic               error_reg;
    logic               done_reg;

    // Load formatting: clamp the element size and lift a zero length to one.
    rec_t load_rec;
    logic [63:0] load_start_ext;
    logic [ADDR_BITS-1:0] load_ptr;
    logic src_full, dst_full;

    always_comb
    begin
        load_rec.start  = rec_start;
        load_rec.esize  = (rec_elem_size > ES_MAX) ? ES_MAX : rec_elem_size;
        load_rec.stride = rec_stride;
        load_rec.length = (rec_length == '0) ? LEN_W'(1) : rec_length;
    end

    assign load_start_ext = 64'(rec_start);
    assign load_ptr       = load_start_ext[ADDR_BITS-1:0];
    assign src_full       = (src_count_reg >= CNT_MAX);
    assign dst_full       = (dst_count_reg >= CNT_MAX);

    // Read addresses: the current record, then the one after it.
    logic [CNT_W-1:0] src_idx_p1, dst_idx_p1;
    logic [IDX_W-1:0] src_rd_addr, dst_rd_addr;

    assign src_idx_p1  = src_idx_reg + CNT_W'(1);
    assign dst_idx_p1  = dst_idx_reg + CNT_W'(1);
    assign src_rd_addr = cmd.calc ? src_idx_p1[IDX_W-1:0] : src_idx_reg[IDX_W-1:0];
    assign dst_rd_addr = cmd.calc ? dst_idx_p1[IDX_W-1:0] : dst_idx_reg[IDX_W-1:0];

    // Table writes on load, registered reads during a step.
    always_ff @(posedge clk)
    begin
        if (cmd.load_src && !src_full)
            src_mem[src_count_reg[IDX_W-1:0]] <= load_rec;
        if (cmd.load_dst && !dst_full)
            dst_mem[dst_count_reg[IDX_W-1:0]] <= load_rec;
        if (cmd.rd_cur || cmd.calc)
        begin
            src_rd_reg <= src_mem[src_rd_addr];
            dst_rd_reg <= dst_mem[dst_rd_addr];
        end
    end

    // Step size: the shorter remaining run for two contiguous records, else one element.
    logic [LEN_W-1:0] src_rem, dst_rem, elems;
    logic             unit_stride;
    logic [LEN_W+ES_W-1:0] bcnt_full;

    always_comb
    begin
        unit_stride = (src_rd_reg.stride == STRIDE_W'(1)) &&
                      (dst_rd_reg.stride == STRIDE_W'(1));
        src_rem     = src_rd_reg.length - src_pos_reg;
        dst_rem     = dst_rd_reg.length - dst_pos_reg;
        if (unit_stride)
            elems = (src_rem < dst_rem) ? src_rem : dst_rem;
        else
            elems = LEN_W'(1);
        bcnt_full = elems * src_rd_reg.esize;
    end

    // Calculation and multiply stages.
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            elems_reg      <= elems;
            bcnt_reg       <= bcnt_full[BCNT_W-1:0];
            src_stride_reg <= src_rd_reg.stride;
            dst_stride_reg <= dst_rd_reg.stride;
            src_len_reg    <= src_rd_reg.length;
            dst_len_reg    <= dst_rd_reg.length;
            mismatch_reg   <= (src_rd_reg.esize != dst_rd_reg.esize);
        end
        if (cmd.mul)
        begin
            src_delta_reg <= bcnt_reg * src_stride_reg;
            dst_delta_reg <= bcnt_reg * dst_stride_reg;
        end
    end

    // Advance of both chains at commit; the next record was read during calculation.
    logic [63:0]          src_delta_ext, dst_delta_ext;
    logic [63:0]          src_next_start_ext, dst_next_start_ext;
    logic [ADDR_BITS-1:0] src_ptr_adv, dst_ptr_adv;
    logic [LEN_W:0]       src_pos_sum, dst_pos_sum;
    logic                 src_wrap, dst_wrap;
    logic [CNT_W-1:0]     src_idx_adv, dst_idx_adv;
    logic [ADDR_BITS-1:0] src_ptr_step, dst_ptr_step;
    logic                 src_done_new, dst_done_new;

    always_comb
    begin
        src_delta_ext      = 64'(src_delta_reg);
        dst_delta_ext      = 64'(dst_delta_reg);
        src_next_start_ext = 64'(src_rd_reg.start);
        dst_next_start_ext = 64'(dst_rd_reg.start);
        src_ptr_adv        = src_ptr_reg + src_delta_ext[ADDR_BITS-1:0];
        dst_ptr_adv        = dst_ptr_reg + dst_delta_ext[ADDR_BITS-1:0];
        src_pos_sum        = {1'b0, src_pos_reg} + {1'b0, elems_reg};
        dst_pos_sum        = {1'b0, dst_pos_reg} + {1'b0, elems_reg};
        src_wrap           = (src_pos_sum >= {1'b0, src_len_reg});
        dst_wrap           = (dst_pos_sum >= {1'b0, dst_len_reg});
        src_idx_adv        = src_wrap ? src_idx_p1 : src_idx_reg;
        dst_idx_adv        = dst_wrap ? dst_idx_p1 : dst_idx_reg;
        if (src_wrap && (src_idx_p1 < src_count_reg))
            src_ptr_step = src_next_start_ext[ADDR_BITS-1:0];
        else
            src_ptr_step = src_ptr_adv;
        if (dst_wrap && (dst_idx_p1 < dst_count_reg))
            dst_ptr_step = dst_next_start_ext[ADDR_BITS-1:0];
        else
            dst_ptr_step = dst_ptr_adv;
        src_done_new       = (src_idx_adv >= src_count_reg);
        dst_done_new       = (dst_idx_adv >= dst_count_reg);
    end

    // Next chain state for loads, clears and commits.
    always_comb
    begin
        src_count_next = src_count_reg;
        dst_count_next = dst_count_reg;
        src_idx_next   = src_idx_reg;
        dst_idx_next   = dst_idx_reg;
        src_pos_next   = src_pos_reg;
        dst_pos_next   = dst_pos_reg;
        src_ptr_next   = src_ptr_reg;
        dst_ptr_next   = dst_ptr_reg;
        if (cmd.clear)
        begin
            src_count_next = '0;
            dst_count_next = '0;
            src_idx_next   = '0;
            dst_idx_next   = '0;
            src_pos_next   = '0;
            dst_pos_next   = '0;
            src_ptr_next   = '0;
            dst_ptr_next   = '0;
        end
        else if (cmd.load_src && !src_full)
        begin
            src_count_next = src_count_reg + CNT_W'(1);
            if ((src_count_reg == src_idx_reg) && (src_pos_reg == '0))
                src_ptr_next = load_ptr;
        end
        else if (cmd.load_dst && !dst_full)
        begin
            dst_count_next = dst_count_reg + CNT_W'(1);
            if ((dst_count_reg == dst_idx_reg) && (dst_pos_reg == '0))
                dst_ptr_next = load_ptr;
        end
        else if (cmd.commit)
        begin
            src_idx_next = src_idx_adv;
            dst_idx_next = dst_idx_adv;
            src_pos_next = src_wrap ? '0 : src_pos_sum[LEN_W-1:0];
            dst_pos_next = dst_wrap ? '0 : dst_pos_sum[LEN_W-1:0];
            src_ptr_next = src_ptr_step;
            dst_ptr_next = dst_ptr_step;
        end
    end

    // Chain state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_count_reg <= '0;
            dst_count_reg <= '0;
            src_idx_reg   <= '0;
            dst_idx_reg   <= '0;
            src_pos_reg   <= '0;
            dst_pos_reg   <= '0;
            src_ptr_reg   <= '0;
            dst_ptr_reg   <= '0;
        end
        else
        begin
            src_count_reg <= src_count_next;
            dst_count_reg <= dst_count_next;
            src_idx_reg   <= src_idx_next;
            dst_idx_reg   <= dst_idx_next;
            src_pos_reg   <= src_pos_next;
            dst_pos_reg   <= dst_pos_next;
            src_ptr_reg   <= src_ptr_next;
            dst_ptr_reg   <= dst_ptr_next;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.commit || cmd.emit_idle;
    end

    // Result payload: a full command at commit, an empty final one after completion.
    logic [63:0] src_out_ext, dst_out_ext;
    assign src_out_ext = 64'(src_ptr_reg);
    assign dst_out_ext = 64'(dst_ptr_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            src_addr_reg   <= src_out_ext[START_W-1:0];
            dst_addr_reg   <= dst_out_ext[START_W-1:0];
            byte_count_reg <= bcnt_reg;
            last_reg       <= src_done_new || dst_done_new;
            error_reg      <= mismatch_reg || (src_done_new != dst_done_new);
        end
        else if (cmd.emit_idle)
        begin
            src_addr_reg   <= '0;
            dst_addr_reg   <= '0;
            byte_count_reg <= '0;
            last_reg       <= 1'b1;
            error_reg      <= sts.src_done != sts.dst_done;
        end
    end

    assign sts.src_done = (src_idx_reg >= src_count_reg);
    assign sts.dst_done = (dst_idx_reg >= dst_count_reg);
    assign src_addr     = src_addr_reg;
    assign dst_addr     = dst_addr_reg;
    assign byte_count   = byte_count_reg;
    assign last_cmd     = last_reg;
    assign chain_error  = error_reg;
    assign done         = done_reg;

    // The current record index never passes the number of loaded records.
    `SCW_ASSERT_ALWAYS(a_src_idx_bound, clk, rst_n, src_idx_reg <= src_count_reg)
    `SCW_ASSERT_ALWAYS(a_dst_idx_bound, clk, rst_n, dst_idx_reg <= dst_count_reg)
    // A command after completion carries no bytes and the last mark.
    `SCW_ASSERT_NEXT(a_idle_result, clk, rst_n, cmd.emit_idle, done_reg && last_reg && (byte_count_reg == '0))

endmodule

@@ rtl/core/strided_chain_copy_walker.sv @@
// Top level of the strided chain copy walker: controller plus datapath.
//
//  Channel   Direction  Handshake             Payload
//  request   in         start & !busy         req_type, rec_start, rec_elem_size,
//                                             rec_stride, rec_length
//  result    out        done (one cycle)      src_addr, dst_addr, byte_count,
//                                             last_cmd, chain_error
//
// Loads and clears never raise busy, so the next request may follow at once.
// A copy step on a finished chain gives its result in the next cycle, also without busy.
// Any other copy step reads its records at the accepting edge, then keeps busy high through
// the step size and byte count, pointer multiply and pointer update states; its result
// appears in the cycle after the update, and no new request is taken before then.
// Reset empties both tables and zeroes indices, positions and pointers; no clearing pass.
// The receiver cannot stall: each result is shown for exactly the one cycle that done marks.
`include "assert_macros.svh"

module strided_chain_copy_walker #(
    parameter int MAX_RECORDS = scw_pkg::MAX_RECORDS_DEF,
    parameter int ADDR_BITS   = scw_pkg::ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      req_type,
    input  logic [scw_pkg::START_W-1:0]     rec_start,
    input  logic [scw_pkg::ES_W-1:0]        rec_elem_size,
    input  logic [scw_pkg::STRIDE_W-1:0]    rec_stride,
    input  logic [scw_pkg::LEN_W-1:0]       rec_length,
    output logic                            done,
    output logic [scw_pkg::START_W-1:0]     src_addr,
    output logic [scw_pkg::START_W-1:0]     dst_addr,
    output logic [scw_pkg::BCNT_W-1:0]      byte_count,
    output logic                            last_cmd,
    output logic                            chain_error
);
    import scw_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer for requests and copy steps.
    scw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Tables, pointers and step arithmetic.
    scw_dp #(
        .MAX_RECORDS (MAX_RECORDS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .rec_start     (rec_start),
        .rec_elem_size (rec_elem_size),
        .rec_stride    (rec_stride),
        .rec_length    (rec_length),
        .src_addr      (src_addr),
        .dst_addr      (dst_addr),
        .byte_count    (byte_count),
        .last_cmd      (last_cmd),
        .chain_error   (chain_error),
        .done          (done)
    );

    // A result is only ever presented while the block is free for the next request.
    `SCW_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)

endmodule
